@@ hdl/url_form_decoder_top_macros.svh @@
// Assertion helpers for the form decoder; clk_i and rst_ni are taken from the
// module that uses them.
`ifndef URL_FORM_DECODER_TOP_MACROS_SVH
`define URL_FORM_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define UFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ufd_pkg.sv @@
package ufd_pkg;

  localparam int MAX_LENGTH_DEF = 1024;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_KEY    = 3'd1,
    PH_SKIPWS = 3'd2,
    PH_VALUE  = 3'd3,
    PH_TAIL   = 3'd4,
    PH_EMPTY  = 3'd5
  } phase_e;

  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_VAL  = 2'd1;
  localparam logic [1:0] KIND_PAIR = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CASE_MASK = 8'hdf;

  // unchecked hex digit: letters fold to upper case, anything else is c - '0'
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] r;
    if (c >= CH_UPA) begin
      r = (c & CASE_MASK) - CH_UPA + 8'd10;
    end else begin
      r = c - CH_ZERO;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

endpackage

@@ hdl/url_form_decoder_top.sv @@
// A request's first result is offered in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one result and the result
//   port is not stalled; a byte that gives two or three results (key or value byte, end of
//   pair, end of request) holds the input while the result port moves them one a cycle.
// Reset: rst_ni clears parser state and drops any pending results at once.
module url_form_decoder_top
  import ufd_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       request_ok_o
);

  localparam int CntW = $clog2(MAX_LENGTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_LENGTH);

  // parser state
  phase_e          phase_q, phase_d;
  logic [1:0]      esc_q, esc_d;
  logic [7:0]      hi_q, hi_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ended_q, ended_d;

  // pending results: byte, end of pair, end of request, sent in that order
  logic       slot_byte_q, slot_pair_q, slot_end_q;
  logic       slot_byte_d, slot_pair_d, slot_end_d;
  logic       rem_byte, rem_pair, rem_end;
  logic [1:0] byte_kind_q, byte_kind_d;
  logic [7:0] byte_val_q, byte_val_d;
  logic       ok_q, ok_d;

  logic       in_fire, out_fire;
  logic       new_byte, new_pair, new_end;
  logic       do_val, vchar;
  logic [7:0] vdec;
  logic [7:0] hexd;

  assign out_valid_o = slot_byte_q | slot_pair_q | slot_end_q;
  assign out_fire    = out_valid_o & ~out_stall_i;
  assign hexd        = hex_value(data_byte_i);

  // drop the slot being taken this cycle
  always_comb begin
    rem_byte = slot_byte_q;
    rem_pair = slot_pair_q;
    rem_end  = slot_end_q;
    if (out_fire) begin
      if (slot_byte_q) begin
        rem_byte = 1'b0;
      end else if (slot_pair_q) begin
        rem_pair = 1'b0;
      end else begin
        rem_end = 1'b0;
      end
    end
  end

  assign in_stall_o = rem_byte | rem_pair | rem_end;
  assign in_fire    = in_valid_i & ~in_stall_o;

  always_comb begin
    kind_o       = KIND_END;
    out_byte_o   = 8'h00;
    request_ok_o = 1'b0;
    if (slot_byte_q) begin
      kind_o     = byte_kind_q;
      out_byte_o = byte_val_q;
    end else if (slot_pair_q) begin
      kind_o = KIND_PAIR;
    end else begin
      request_ok_o = ok_q;
    end
  end

  // one request byte through the parser
  always_comb begin
    phase_d     = phase_q;
    esc_d       = esc_q;
    hi_d        = hi_q;
    cnt_d       = cnt_q;
    ended_d     = ended_q;
    new_byte    = 1'b0;
    new_pair    = 1'b0;
    new_end     = 1'b0;
    byte_kind_d = KIND_KEY;
    byte_val_d  = data_byte_i;
    ok_d        = 1'b0;
    do_val      = 1'b0;
    vchar       = 1'b0;
    vdec        = data_byte_i;

    if (!ended_q) begin
      if (data_byte_i == 8'h00) begin
        ended_d = 1'b1;
        esc_d   = ESC_NONE;
        hi_d    = 8'h00;
      end else begin
        if (cnt_q < CntMax) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (data_byte_i == CH_AMP) begin
          new_pair = (phase_q != PH_START);
          phase_d  = PH_START;
          esc_d    = ESC_NONE;
          hi_d     = 8'h00;
        end else begin
          case (phase_q)
            PH_START: begin
              if (data_byte_i == CH_EQ) begin
                phase_d = PH_EMPTY;
              end else begin
                new_byte = 1'b1;
                phase_d  = PH_KEY;
              end
            end
            PH_KEY: begin
              if (data_byte_i == CH_EQ) begin
                phase_d = PH_SKIPWS;
              end else begin
                new_byte = 1'b1;
              end
            end
            PH_SKIPWS: begin
              if (!is_space(data_byte_i)) begin
                phase_d = PH_VALUE;
                do_val  = 1'b1;
              end
            end
            PH_VALUE: begin
              if (is_space(data_byte_i)) begin
                phase_d = PH_TAIL;
                esc_d   = ESC_NONE;
                hi_d    = 8'h00;
              end else begin
                do_val = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    // percent decoding of value bytes
    if (do_val) begin
      case (esc_q)
        ESC_NONE: begin
          if (data_byte_i == CH_PCT) begin
            esc_d = ESC_HIGH;
          end else begin
            vchar = 1'b1;
          end
        end
        ESC_HIGH: begin
          hi_d  = {hexd[3:0], 4'h0};
          esc_d = ESC_LOW;
        end
        default: begin
          vdec  = hi_q + hexd;
          vchar = 1'b1;
          esc_d = ESC_NONE;
          hi_d  = 8'h00;
        end
      endcase
      if (vchar) begin
        if (vdec == 8'h00) begin
          phase_d = PH_TAIL;
        end else begin
          new_byte    = 1'b1;
          byte_kind_d = KIND_VAL;
          byte_val_d  = (vdec == CH_PLUS) ? CH_SPACE : vdec;
        end
      end
    end

    if (last_i) begin
      ok_d     = (cnt_d != '0) && (cnt_d < CntMax);
      new_pair = new_pair | (phase_d != PH_START);
      new_end  = 1'b1;
      phase_d  = PH_START;
      esc_d    = ESC_NONE;
      hi_d     = 8'h00;
      cnt_d    = '0;
      ended_d  = 1'b0;
    end
  end

  assign slot_byte_d = in_fire ? new_byte : rem_byte;
  assign slot_pair_d = in_fire ? new_pair : rem_pair;
  assign slot_end_d  = in_fire ? new_end  : rem_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      esc_q       <= ESC_NONE;
      hi_q        <= 8'h00;
      cnt_q       <= '0;
      ended_q     <= 1'b0;
      slot_byte_q <= 1'b0;
      slot_pair_q <= 1'b0;
      slot_end_q  <= 1'b0;
    end else begin
      slot_byte_q <= slot_byte_d;
      slot_pair_q <= slot_pair_d;
      slot_end_q  <= slot_end_d;
      if (in_fire) begin
        phase_q <= phase_d;
        esc_q   <= esc_d;
        hi_q    <= hi_d;
        cnt_q   <= cnt_d;
        ended_q <= ended_d;
      end
    end
  end

  // result payload; held while a result is pending
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_kind_q <= byte_kind_d;
      byte_val_q  <= byte_val_d;
      ok_q        <= ok_d;
    end
  end

`include "url_form_decoder_top_macros.svh"

  `UFD_ASSERT_NEXT(a_last_resets, in_fire && last_i, phase_q == PH_START && cnt_q == '0 && !ended_q, "parser state not cleared after last byte")
  `UFD_ASSERT_NOW(a_hi_idle, esc_q != ESC_LOW, hi_q == 8'h00, "high nibble held outside an escape")
  `UFD_ASSERT_NOW(a_ok_on_end, out_valid_o && request_ok_o, kind_o == KIND_END, "request_ok raised on a non-end result")

endmodule
